// File: hw/rtl/lzwc_pkg.sv
`timescale 1ns / 1ps

package lzwc_pkg;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 13;
   localparam int EPOCH_W = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // The first code past the single-byte codes.
   localparam int FIRST_FREE = 256;

   // A table slot whose tag differs from the current epoch is empty.
   // Tag zero is what the clearing pass writes, so epochs run from one up.
   localparam logic [EPOCH_W-1:0] EPOCH_CLEARED = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST   = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST    = '1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_EMIT_PREFIX,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic hit;
      logic empty;
   } probe_result_type;

endpackage

// File: hw/rtl/lzwc_dict_ram.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read table with a registered read.
module lzwc_dict_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lzwc_probe_unit.sv
`timescale 1ns / 1ps

// Hashes a (prefix, byte) key to a home slot, steps the probe address and
// checks a slot read from the table against the key being searched.
module lzwc_probe_unit #(
   parameter int CODE_BITS = 12
) (
   input  logic [CODE_BITS-1:0]                  hash_prefix,
   input  logic [lzwc_pkg::BYTE_W-1:0]           hash_byte,
   output logic [CODE_BITS-1:0]                  home_addr,
   input  logic [CODE_BITS-1:0]                  probe_addr,
   output logic [CODE_BITS-1:0]                  step_addr,
   input  logic [CODE_BITS+lzwc_pkg::BYTE_W-1:0] search_key,
   input  logic [lzwc_pkg::EPOCH_W-1:0]          epoch,
   input  logic [CODE_BITS+lzwc_pkg::BYTE_W-1:0] slot_key,
   input  logic [lzwc_pkg::EPOCH_W-1:0]          slot_epoch,
   output lzwc_pkg::probe_result_type            result
);

   // The byte is XORed into the top bits of the index, while the prefix
   // covers all of its bits.
   assign home_addr = hash_prefix ^ {hash_byte, {(CODE_BITS-lzwc_pkg::BYTE_W){1'b0}}};
   assign step_addr = probe_addr + CODE_BITS'(1);

   always_comb begin
      result.empty = (slot_epoch != epoch);
      result.hit   = (slot_epoch == epoch) && (slot_key == search_key);
   end

endmodule

// File: hw/rtl/lzwc_out_reg.sv
`timescale 1ns / 1ps

// Output register holding one emitted code until the consumer takes it.
module lzwc_out_reg #(
   parameter int CODE_BITS = 12,
   parameter int DATA_W    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [CODE_BITS-1:0] load_code,
   input  logic                 load_last,
   output logic                 free,
   output logic                 m_valid,
   input  logic                 m_ready,
   output logic [DATA_W-1:0]    m_data,
   output logic                 m_last
);

   logic                 valid_ff, valid_in;
   logic [CODE_BITS-1:0] code_ff;
   logic                 last_ff;

   assign free = !valid_ff || m_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (m_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= load_code;
         last_ff <= load_last;
      end
   end

   assign m_valid = valid_ff;
   assign m_data  = DATA_W'(code_ff);
   assign m_last  = last_ff;

endmodule

// File: hw/rtl/lzw_byte_compressor_unit.sv
`timescale 1ns / 1ps

// LZW byte compressor with CODE_BITS-wide codes. Each request carries one
// byte (req_tdata) and an end-of-stream mark (req_tlast); each response
// carries one code (rsp_tdata) with rsp_tlast set on the final code of a
// stream. The dictionary is a hash table of 2^CODE_BITS slots in one
// memory, searched by linear probing with one slot compared per cycle by a
// shared probe unit. The first byte of a stream only becomes the prefix.
// Any later byte is probed from its home slot: a hit makes the slot's code
// the prefix, while an empty slot ends the chain and is followed by a step
// that emits the code; each further slot probed adds a step, and the final
// code of a stream takes one more step. An emit also waits for as long as
// the output register holds a code that the consumer has not taken. Each
// slot is tagged with a stream epoch, so a new stream starts with an empty
// dictionary at once. After reset, and after every 255 streams that added
// entries, the table is swept with one slot cleared per cycle, during
// which no request is taken; csr writes are taken at any time. A code
// waiting in the output register does not keep the next request from
// being accepted.
module lzw_byte_compressor_unit #(
   parameter int CODE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,

   // Code limit register: number of codes allowed in the dictionary.
   input  logic                                csr_we,
   input  logic [lzwc_pkg::LIMIT_W-1:0]        csr_wdata,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from the lowest: data_byte[7:0].
   input  logic [lzwc_pkg::BYTE_W-1:0]         req_tdata,
   // end_of_stream.
   input  logic                                req_tlast,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from the lowest: out_code[CODE_BITS-1:0], then zero fill.
   output logic [((CODE_BITS+7)/8)*8-1:0]      rsp_tdata,
   // last_code.
   output logic                                rsp_tlast
);

   localparam int RSP_W   = ((CODE_BITS + 7) / 8) * 8;
   localparam int KEY_W   = CODE_BITS + lzwc_pkg::BYTE_W;
   localparam int ENTRY_W = KEY_W + CODE_BITS + lzwc_pkg::EPOCH_W;
   localparam int NF_W    = CODE_BITS + 1;
   localparam int CMP_W   = (NF_W > lzwc_pkg::LIMIT_W) ? NF_W : lzwc_pkg::LIMIT_W;

   localparam logic [NF_W-1:0] DICT_SIZE  = NF_W'(1) << CODE_BITS;
   localparam logic [NF_W-1:0] FIRST_CODE = NF_W'(lzwc_pkg::FIRST_FREE);

   // Sequencer and stream state.
   lzwc_pkg::state_type             state_ff, state_in;
   logic [CODE_BITS-1:0]            prefix_ff, prefix_in;
   logic                            pvalid_ff, pvalid_in;
   logic [NF_W-1:0]                 next_free_ff, next_free_in;
   logic [lzwc_pkg::EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [lzwc_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [CODE_BITS-1:0]            addr_ff, addr_in;

   // The request being worked on.
   logic [lzwc_pkg::BYTE_W-1:0]     byte_ff;
   logic                            eos_ff;

   // Table ports.
   logic                            wr_en;
   logic [CODE_BITS-1:0]            rd_addr;
   logic [ENTRY_W-1:0]              wr_data;
   logic [ENTRY_W-1:0]              rd_data;

   // Probe unit.
   logic [CODE_BITS-1:0]            home_addr;
   logic [CODE_BITS-1:0]            step_addr;
   logic [KEY_W-1:0]                search_key;
   logic [KEY_W-1:0]                slot_key;
   logic [CODE_BITS-1:0]            slot_code;
   logic [lzwc_pkg::EPOCH_W-1:0]    slot_epoch;
   lzwc_pkg::probe_result_type      probe;

   // Output register.
   logic                            out_load;
   logic                            out_last;
   logic                            out_free;

   logic                            accept;
   logic                            room;
   logic                            clear_done;
   logic                            stream_grew;

   assign accept     = req_tvalid && req_tready;
   assign search_key = {prefix_ff, byte_ff};
   assign slot_key   = rd_data[KEY_W-1:0];
   assign slot_code  = rd_data[KEY_W +: CODE_BITS];
   assign slot_epoch = rd_data[KEY_W+CODE_BITS +: lzwc_pkg::EPOCH_W];
   assign clear_done = (addr_ff == '1);

   // A new entry is allowed below both the code limit and the table size.
   assign room = (next_free_ff < DICT_SIZE)
              && (CMP_W'(next_free_ff) < CMP_W'(limit_ff));

   // Streams that added no entries leave no tags behind, so they keep
   // their epoch and do not bring the next clearing pass closer.
   assign stream_grew = (next_free_ff != FIRST_CODE);

   lzwc_probe_unit #(
      .CODE_BITS (CODE_BITS)
   ) u_probe (
      .hash_prefix (prefix_ff),
      .hash_byte   (req_tdata),
      .home_addr   (home_addr),
      .probe_addr  (addr_ff),
      .step_addr   (step_addr),
      .search_key  (search_key),
      .epoch       (epoch_ff),
      .slot_key    (slot_key),
      .slot_epoch  (slot_epoch),
      .result      (probe)
   );

   lzwc_dict_ram #(
      .ADDR_W (CODE_BITS),
      .DATA_W (ENTRY_W)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwc_out_reg #(
      .CODE_BITS (CODE_BITS),
      .DATA_W    (RSP_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_code (prefix_ff),
      .load_last (out_last),
      .free      (out_free),
      .m_valid   (rsp_tvalid),
      .m_ready   (rsp_tready),
      .m_data    (rsp_tdata),
      .m_last    (rsp_tlast)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            if (clear_done) begin
               state_in = lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_IDLE: begin
            if (accept) begin
               if (pvalid_ff) begin
                  state_in = lzwc_pkg::ST_PROBE;
               end else if (req_tlast) begin
                  state_in = lzwc_pkg::ST_EMIT_LAST;
               end
            end
         end
         lzwc_pkg::ST_PROBE: begin
            if (probe.hit) begin
               state_in = eos_ff ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
            end else if (probe.empty) begin
               state_in = lzwc_pkg::ST_EMIT_PREFIX;
            end
         end
         lzwc_pkg::ST_EMIT_PREFIX: begin
            if (out_free) begin
               state_in = eos_ff ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
            end
         end
         lzwc_pkg::ST_EMIT_LAST: begin
            if (out_free) begin
               if (stream_grew && (epoch_ff == lzwc_pkg::EPOCH_LAST)) begin
                  state_in = lzwc_pkg::ST_CLEAR;
               end else begin
                  state_in = lzwc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lzwc_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      wr_en      = 1'b0;
      wr_data    = {lzwc_pkg::EPOCH_CLEARED, {(KEY_W+CODE_BITS){1'b0}}};
      rd_addr    = step_addr;
      out_load   = 1'b0;
      out_last   = 1'b0;
      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
         end
         lzwc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = home_addr;
         end
         lzwc_pkg::ST_PROBE: begin
            // An empty slot ends the chain: the new entry goes there if there is room.
            if (probe.empty && room) begin
               wr_en   = 1'b1;
               wr_data = {epoch_ff, next_free_ff[CODE_BITS-1:0], search_key};
            end
         end
         lzwc_pkg::ST_EMIT_PREFIX: begin
            out_load = out_free;
         end
         lzwc_pkg::ST_EMIT_LAST: begin
            out_load = out_free;
            out_last = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Next values of the working registers.
   always_comb begin
      prefix_in    = prefix_ff;
      pvalid_in    = pvalid_ff;
      next_free_in = next_free_ff;
      epoch_in     = epoch_ff;
      addr_in      = addr_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            addr_in = step_addr;
         end
         lzwc_pkg::ST_IDLE: begin
            addr_in = home_addr;
            if (accept && !pvalid_ff) begin
               prefix_in = CODE_BITS'(req_tdata);
               pvalid_in = 1'b1;
            end
         end
         lzwc_pkg::ST_PROBE: begin
            addr_in = step_addr;
            if (probe.hit) begin
               prefix_in = slot_code;
            end else if (probe.empty) begin
               addr_in = addr_ff;
               if (room) begin
                  next_free_in = next_free_ff + NF_W'(1);
               end
            end
         end
         lzwc_pkg::ST_EMIT_PREFIX: begin
            if (out_free) begin
               prefix_in = CODE_BITS'(byte_ff);
            end
         end
         lzwc_pkg::ST_EMIT_LAST: begin
            if (out_free) begin
               prefix_in    = '0;
               pvalid_in    = 1'b0;
               next_free_in = FIRST_CODE;
               addr_in      = '0;
               if (stream_grew) begin
                  if (epoch_ff == lzwc_pkg::EPOCH_LAST) begin
                     epoch_in = lzwc_pkg::EPOCH_FIRST;
                  end else begin
                     epoch_in = epoch_ff + lzwc_pkg::EPOCH_W'(1);
                  end
               end
            end
         end
         default: begin
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwc_pkg::ST_CLEAR;
         prefix_ff    <= '0;
         pvalid_ff    <= 1'b0;
         next_free_ff <= FIRST_CODE;
         epoch_ff     <= lzwc_pkg::EPOCH_FIRST;
         limit_ff     <= lzwc_pkg::LIMIT_RESET;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         pvalid_ff    <= pvalid_in;
         next_free_ff <= next_free_in;
         epoch_ff     <= epoch_in;
         limit_ff     <= limit_in;
         addr_ff      <= addr_in;
      end
   end

   // The accepted byte and its end mark are held for the probe and emit steps.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_tdata;
         eos_ff  <= req_tlast;
      end
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CODE_W     = 12;
   localparam int RSP_W      = ((CODE_W + 7) / 8) * 8;
   localparam int TABLE_SIZE = 1 << CODE_W;
   localparam int MAX_CYCLES = 400000;
   // Cycles left for the block to finish a probe chain before a register write.
   localparam int SETTLE     = 300;
   localparam int HOLD_LONG  = 400;

   localparam int BYTE_W     = lzwc_pkg::BYTE_W;
   localparam int LIMIT_W    = lzwc_pkg::LIMIT_W;
   localparam int FIRST_FREE = lzwc_pkg::FIRST_FREE;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = lzwc_pkg::LIMIT_RESET;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              eos;
   } stream_byte_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic              last;
   } lzw_code_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [LIMIT_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;

   lzw_byte_compressor_unit #(
      .CODE_BITS(CODE_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bytes waiting to be offered, and codes the encoder still owes.
   stream_byte_type byte_backlog[$];
   lzw_code_type    lzw_codes_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holdoff_asks   = 0;
   int holdoff_seen   = 0;
   int holdoff_left   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Shadow of the encoder: prefix, next free code, dictionary and limit.
   logic [CODE_W-1:0]  cur_prefix  = '0;
   logic               have_prefix = 1'b0;
   logic [LIMIT_W-1:0] next_code   = LIMIT_W'(FIRST_FREE);
   logic [LIMIT_W-1:0] limit_copy  = LIMIT_RESET;
   logic [CODE_W+BYTE_W-1:0] code_table [TABLE_SIZE];

   // Runs one accepted byte through the shadow encoder and records the codes it emits.
   function automatic void lzw_encode_byte(input logic [BYTE_W-1:0] b,
                                           input logic eos);
      logic [CODE_W+BYTE_W-1:0] key;
      logic [LIMIT_W-1:0]       cap;
      int                       hit_code;
      lzw_code_type             owed;
      hit_code = -1;
      if (!have_prefix) begin
         cur_prefix  = CODE_W'(b);
         have_prefix = 1'b1;
      end else begin
         key = {cur_prefix, b};
         for (int k = FIRST_FREE; k < int'(next_code); k++) begin
            if (hit_code < 0 && code_table[k] == key) hit_code = k;
         end
         if (hit_code >= 0) begin
            cur_prefix = CODE_W'(hit_code);
         end else begin
            cap = (limit_copy < LIMIT_W'(TABLE_SIZE)) ? limit_copy : LIMIT_W'(TABLE_SIZE);
            owed.code     = cur_prefix;
            owed.last     = 1'b0;
            lzw_codes_due = {lzw_codes_due, owed};
            if (next_code < cap) begin
               code_table[next_code[CODE_W-1:0]] = key;
               next_code = next_code + 1'b1;
            end
            cur_prefix = CODE_W'(b);
         end
      end
      if (eos) begin
         owed.code     = cur_prefix;
         owed.last     = 1'b1;
         lzw_codes_due = {lzw_codes_due, owed};
         cur_prefix  = '0;
         have_prefix = 1'b0;
         next_code   = LIMIT_W'(FIRST_FREE);
      end
   endfunction

   // Request side: a byte is predicted when its handshake completes, and a new
   // one is offered whenever the slot is free and the sender is not idling.
   always @(posedge clock) begin : request_driver
      stream_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) lzw_encode_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.eos;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off is counted down here, apart from the random stalls.
   // Each new ask from the stimulus reloads the count.
   always @(posedge clock) begin
      if (holdoff_seen != holdoff_asks) begin
         holdoff_seen <= holdoff_asks;
         holdoff_left <= HOLD_LONG;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Response side: every accepted code is checked against the oldest one owed.
   always @(posedge clock) begin : response_monitor
      lzw_code_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (lzw_codes_due.size() == 0) begin
               $display("%0t: code with none owed: expected nothing, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               due = lzw_codes_due.pop_front();
               if (rsp_tdata !== RSP_W'(due.code)) begin
                  $display("%0t: out_code expected %h, actual %h", $time, due.code, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== due.last) begin
                  $display("%0t: last_code expected %b, actual %b", $time, due.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (holdoff_left > 0) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The register is only written once every request has been accepted and
   // every owed code has come out, plus a settling gap.
   task automatic wait_idle(input int settle);
      @(negedge clock);
      while (byte_backlog.size() != 0 || req_tvalid || lzw_codes_due.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_code_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      limit_copy  = value;
      @(negedge clock);
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic eos);
      stream_byte_type item;
      item.data    = data;
      item.eos     = eos;
      byte_backlog = {byte_backlog, item};
   endtask

   // Most streams draw from a tiny alphabet so the dictionary gets hits; some
   // are plain random bytes. A few are long enough to fill small dictionaries.
   task automatic queue_random_stream(output int len);
      int               kind;
      int               alpha_n;
      logic [BYTE_W-1:0] alphabet [4];
      logic [BYTE_W-1:0] b;
      kind    = $urandom_range(9);
      len     = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(30, 120);
      alpha_n = $urandom_range(1, 4);
      foreach (alphabet[i]) alphabet[i] = BYTE_W'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
         b = (kind < 7) ? alphabet[$urandom_range(alpha_n - 1)] : BYTE_W'($urandom_range(255));
         queue_byte(b, (i == len - 1));
      end
   endtask

   task automatic queue_random_phase(input int target);
      int queued;
      int len;
      queued = 0;
      while (queued < target) begin
         queue_random_stream(len);
         queued += len;
      end
   endtask

   initial begin : stimulus
      logic [LIMIT_W-1:0] phase_limit;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_code_limit(LIMIT_RESET);

      // One-byte streams at both ends of the byte range.
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      // Repeating pair, so later bytes hit entries added earlier.
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b0);
      queue_byte(8'h41, 1'b1);
      // Last byte misses: the prefix code is emitted, then the byte code.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle(SETTLE);

      // Limit at the single-byte codes: nothing is ever added.
      write_code_limit(LIMIT_W'(FIRST_FREE));
      repeat (4) queue_byte(8'hAA, 1'b0);
      queue_byte(8'hAA, 1'b1);
      wait_idle(SETTLE);

      // Room for exactly one entry, then the dictionary is full.
      write_code_limit(LIMIT_W'(FIRST_FREE + 1));
      repeat (4) queue_byte(8'h55, 1'b0);
      queue_byte(8'h55, 1'b1);
      wait_idle(SETTLE);

      // Limit raised in the middle of a stream.
      write_code_limit(LIMIT_W'(FIRST_FREE));
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h11, 1'b0);
      wait_idle(SETTLE);
      write_code_limit(LIMIT_RESET);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h11, 1'b1);
      wait_idle(SETTLE);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_limit = LIMIT_RESET;
            1: phase_limit = LIMIT_W'(FIRST_FREE);
            2: phase_limit = LIMIT_W'($urandom_range(257, 320));
            3: phase_limit = LIMIT_W'($urandom_range(256, 4096));
            4: phase_limit = LIMIT_W'(TABLE_SIZE - 1);
            5: phase_limit = LIMIT_W'(FIRST_FREE + 1);
            6: phase_limit = LIMIT_W'($urandom_range(300, 1000));
            default: phase_limit = LIMIT_RESET;
         endcase
         write_code_limit(phase_limit);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         queue_random_phase(42);
         wait_idle(SETTLE);
      end

      // Receiver holds off while the sender keeps offering, so the block backs up.
      write_code_limit(LIMIT_W'($urandom_range(260, 600)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_asks   = holdoff_asks + 1;
      queue_random_phase(25);
      wait_idle(SETTLE);

      if (mismatch_count == 0 && lzw_codes_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
